[sv/assert_macros.svh]
// assertion macros shared by the filter modules
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define TSSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define TSSF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/tssf_pkg.sv]
// types and constants of the tagged segment stream filter
// no dependencies; imported by every module of the block
package tssf_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int WORD_WIDTH          = 16;
   localparam int TYPE_WIDTH          = 8;
   localparam int KEPT_WIDTH          = 32;
   localparam int LEFT_WIDTH          = 31;

   localparam logic [WORD_WIDTH-1:0] SEG_MARK_MASK   = 16'hFF80;
   localparam logic [WORD_WIDTH-1:0] LONG_LEN_MARK   = 16'hFFFF;
   localparam logic [TYPE_WIDTH-1:0] DROP_TYPE_RESET = 8'hE0;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEN     = 3'd1,
      PH_LLEN_LO = 3'd2,
      PH_LLEN_HI = 3'd3,
      PH_BODY    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] out_word;
      logic                  forwarded;
      logic [KEPT_WIDTH-1:0] kept_bytes;
      logic                  stream_end;
   } rsp_type;

endpackage

[sv/tssf_parse.sv]
// segment parser: phase state, segment length counter and kept byte total
// depends on tssf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tssf_parse #(
   parameter int COUNT_WIDTH = tssf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [tssf_pkg::WORD_WIDTH-1:0]     word,
   input  logic                                last,
   input  logic [tssf_pkg::TYPE_WIDTH-1:0]     drop_type,
   output tssf_pkg::rsp_type                   result
);
   import tssf_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   dropping_ff, dropping_in;
   logic [WORD_WIDTH-1:0]  low_ff, low_in;
   logic [LEFT_WIDTH-1:0]  left_ff, left_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   logic                   keep;
   logic                   start_en;
   logic [LEFT_WIDTH-1:0]  start_len;
   logic [LEFT_WIDTH-1:0]  left_dec;

   assign left_dec = left_ff - LEFT_WIDTH'(1);

   always_comb begin
      phase_in    = phase_ff;
      dropping_in = dropping_ff;
      low_in      = low_ff;
      left_in     = left_ff;
      keep        = !dropping_ff;
      start_en    = 1'b0;
      start_len   = '0;
      unique case (phase_ff)
         PH_LEN: begin
            if (word == LONG_LEN_MARK) begin
               phase_in = PH_LLEN_LO;
            end else begin
               start_en  = 1'b1;
               start_len = LEFT_WIDTH'(word[WORD_WIDTH-1:1]);
            end
         end
         PH_LLEN_LO: begin
            low_in   = word;
            phase_in = PH_LLEN_HI;
         end
         PH_LLEN_HI: begin
            // low half first, byte length halved into words
            start_en  = 1'b1;
            start_len = {word, low_ff[WORD_WIDTH-1:1]};
            low_in    = '0;
         end
         PH_BODY: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in    = PH_IDLE;
               dropping_in = 1'b0;
            end
         end
         default: begin
            if ((word & SEG_MARK_MASK) == SEG_MARK_MASK) begin
               dropping_in = (word[TYPE_WIDTH-1:0] == drop_type);
               phase_in    = PH_LEN;
               keep        = (word[TYPE_WIDTH-1:0] != drop_type);
            end else begin
               phase_in = PH_IDLE;
               keep     = 1'b1;
            end
         end
      endcase

      // empty body closes the segment straight away
      if (start_en) begin
         left_in = start_len;
         if (start_len == '0) begin
            phase_in    = PH_IDLE;
            dropping_in = 1'b0;
         end else begin
            phase_in = PH_BODY;
         end
      end

      total_in = keep ? total_ff + COUNT_WIDTH'(2) : total_ff;

      result.out_word   = keep ? word : '0;
      result.forwarded  = keep;
      result.kept_bytes = KEPT_WIDTH'(total_in);
      result.stream_end = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         dropping_ff <= 1'b0;
         low_ff      <= '0;
         left_ff     <= '0;
         total_ff    <= '0;
      end else if (accept) begin
         if (last) begin
            phase_ff    <= PH_IDLE;
            dropping_ff <= 1'b0;
            low_ff      <= '0;
            left_ff     <= '0;
            total_ff    <= '0;
         end else begin
            phase_ff    <= phase_in;
            dropping_ff <= dropping_in;
            low_ff      <= low_in;
            left_ff     <= left_in;
            total_ff    <= total_in;
         end
      end
   end

   `TSSF_ASSERT_NXT(a_last_clears, clock, reset, accept && last,
      phase_ff == PH_IDLE && total_ff == '0 && !dropping_ff, "parse state not cleared after last")
   `TSSF_ASSERT_IMP(a_idle_clean, clock, reset, phase_ff == PH_IDLE,
      left_ff == '0 && !dropping_ff, "idle phase with segment state left over")

endmodule

[sv/tssf_out_reg.sv]
// result register between the parser and the result channel
// depends on tssf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tssf_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tssf_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tssf_pkg::rsp_type out_data
);
   import tssf_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // the register frees up in the same cycle its contents are taken
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   `TSSF_ASSERT_IMP(a_no_overwrite, clock, reset, valid_ff && !out_ready, !in_ready,
      "held result would be overwritten")
   `TSSF_ASSERT_NXT(a_load_valid, clock, reset, in_valid && in_ready, valid_ff,
      "transfer in did not produce a result")

endmodule

[sv/tagged_segment_stream_filter.sv]
// Tagged segment stream filter: zeroes and flags out the words of segments of one type in a word stream.
// A result is registered and valid in the cycle after its input transfer.
// Throughput: one word per cycle while the output is not stalled, set by the single parse
// state update per word; the result register takes a new word in the cycle its result goes out.
// Reset (synchronous): parse state and byte count cleared, drop type set to 0xE0.
// Depends on tssf_pkg, tssf_parse and tssf_out_reg.
module tagged_segment_stream_filter #(
   parameter int COUNT_WIDTH = tssf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tssf_pkg::TYPE_WIDTH-1:0]     csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tssf_pkg::WORD_WIDTH-1:0]     req_word,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tssf_pkg::WORD_WIDTH-1:0]     rsp_out_word,
   output logic                                rsp_forwarded,
   output logic [tssf_pkg::KEPT_WIDTH-1:0]     rsp_kept_bytes,
   output logic                                rsp_stream_end
);
   import tssf_pkg::*;

   logic [TYPE_WIDTH-1:0] drop_type_ff;
   rsp_type               parse_rsp;
   rsp_type               held_rsp;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_type_ff <= DROP_TYPE_RESET;
      end else if (csr_wr_en) begin
         drop_type_ff <= csr_wr_data;
      end
   end

   assign accept = req_valid && req_ready;

   tssf_parse #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .word      (req_word),
      .last      (req_last),
      .drop_type (drop_type_ff),
      .result    (parse_rsp)
   );

   tssf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (parse_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (held_rsp)
   );

   assign rsp_out_word   = held_rsp.out_word;
   assign rsp_forwarded  = held_rsp.forwarded;
   assign rsp_kept_bytes = held_rsp.kept_bytes;
   assign rsp_stream_end = held_rsp.stream_end;

endmodule

[test/tb_tagged_segment_stream_filter.sv]
// testbench of tagged_segment_stream_filter: directed and random word streams with handshake stalls
// depends on tssf_pkg and the filter RTL; results are checked against a behavioural scoreboard
module tb_tagged_segment_stream_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import tssf_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 60;

   typedef struct {
      logic [WORD_WIDTH-1:0] word;
      logic                  last;
   } word_item_type;

   // expected results of the filter, worked out word by word
   class segment_filter_scoreboard;
      logic [TYPE_WIDTH-1:0] drop_type;
      phase_type             phase;
      logic                  dropping;
      logic [WORD_WIDTH-1:0] long_low;
      logic [LEFT_WIDTH-1:0] words_left;
      logic [KEPT_WIDTH-1:0] byte_total;
      rsp_type               expected_q[$];
      int                    fail_count;

      function new();
         drop_type  = DROP_TYPE_RESET;
         byte_total = '0;
         fail_count = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         phase      = PH_IDLE;
         dropping   = 1'b0;
         long_low   = '0;
         words_left = '0;
      endfunction

      function void set_drop_type(logic [TYPE_WIDTH-1:0] value);
         drop_type = value;
      endfunction

      function void begin_body(logic [31:0] words);
         words_left = words[LEFT_WIDTH-1:0];
         if (words_left == 0) begin
            phase    = PH_IDLE;
            dropping = 1'b0;
         end else begin
            phase = PH_BODY;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_input(word_item_type item);
         rsp_type               exp_rsp;
         logic                  keep;
         logic [WORD_WIDTH-1:0] w;
         w = item.word;
         case (phase)
            PH_LEN: begin
               keep = !dropping;
               if (w == LONG_LEN_MARK) phase = PH_LLEN_LO;
               else begin_body({16'h0000, w} >> 1);
            end
            PH_LLEN_LO: begin
               keep     = !dropping;
               long_low = w;
               phase    = PH_LLEN_HI;
            end
            PH_LLEN_HI: begin
               keep = !dropping;
               begin_body({w, long_low} >> 1);
               long_low = '0;
            end
            PH_BODY: begin
               keep       = !dropping;
               words_left = words_left - 1'b1;
               if (words_left == 0) begin
                  phase    = PH_IDLE;
                  dropping = 1'b0;
               end
            end
            default: begin
               if ((w & SEG_MARK_MASK) == SEG_MARK_MASK) begin
                  dropping = (w[TYPE_WIDTH-1:0] == drop_type);
                  phase    = PH_LEN;
                  keep     = !dropping;
               end else begin
                  phase = PH_IDLE;
                  keep  = 1'b1;
               end
            end
         endcase
         if (keep) byte_total = byte_total + 32'd2;
         exp_rsp.out_word   = keep ? w : '0;
         exp_rsp.forwarded  = keep;
         exp_rsp.kept_bytes = byte_total;
         exp_rsp.stream_end = item.last;
         expected_q.push_back(exp_rsp);
         // end of stream wipes the parse state even mid segment
         if (item.last) begin
            clear_stream();
            byte_total = '0;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected: word %h", got.out_word);
            fail_count++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (got.out_word !== exp_rsp.out_word) begin
            $error("out_word: expected %h, got %h", exp_rsp.out_word, got.out_word);
            fail_count++;
         end
         if (got.forwarded !== exp_rsp.forwarded) begin
            $error("forwarded: expected %b, got %b", exp_rsp.forwarded, got.forwarded);
            fail_count++;
         end
         if (got.kept_bytes !== exp_rsp.kept_bytes) begin
            $error("kept_bytes: expected %0d, got %0d", exp_rsp.kept_bytes, got.kept_bytes);
            fail_count++;
         end
         if (got.stream_end !== exp_rsp.stream_end) begin
            $error("stream_end: expected %b, got %b", exp_rsp.stream_end, got.stream_end);
            fail_count++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [TYPE_WIDTH-1:0] csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORD_WIDTH-1:0] req_word = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORD_WIDTH-1:0] rsp_out_word;
   logic                  rsp_forwarded;
   logic [KEPT_WIDTH-1:0] rsp_kept_bytes;
   logic                  rsp_stream_end;

   segment_filter_scoreboard sb = new();
   word_item_type            stim_q[$];
   int                       rsp_idle_pct = 0;
   int                       stall_hold = 0;
   int                       quiet_cycles = 0;

   tagged_segment_stream_filter #(.COUNT_WIDTH(32)) DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_word   (rsp_out_word),
      .rsp_forwarded  (rsp_forwarded),
      .rsp_kept_bytes (rsp_kept_bytes),
      .rsp_stream_end (rsp_stream_end)
   );

   always #5 clock = ~clock;

   // receiver: checks each result transfer, stalls at random or for a long hold
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.out_word   = rsp_out_word;
         got.forwarded  = rsp_forwarded;
         got.kept_bytes = rsp_kept_bytes;
         got.stream_end = rsp_stream_end;
         sb.check_result(got);
      end
      if (stall_hold > 0) begin
         rsp_ready  <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic push_item(input logic [WORD_WIDTH-1:0] w, input logic last);
      word_item_type item;
      item.word = w;
      item.last = last;
      stim_q.push_back(item);
   endtask

   task automatic offer_next(input int idx, input int idle_pct);
      if (idx < stim_q.size() && $urandom_range(99) >= idle_pct) begin
         req_valid <= 1'b1;
         req_word  <= stim_q[idx].word;
         req_last  <= stim_q[idx].last;
      end else begin
         req_valid <= 1'b0;
      end
   endtask

   task automatic drive_words(input int idle_pct);
      int idx;
      idx = 0;
      offer_next(idx, idle_pct);
      while (idx < stim_q.size()) begin
         @(posedge clock);
         if (req_valid && req_ready) begin
            sb.note_input(stim_q[idx]);
            idx++;
            offer_next(idx, idle_pct);
         end else if (!req_valid) begin
            offer_next(idx, idle_pct);
         end
      end
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_drop_type(input logic [TYPE_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_drop_type(value);
   endtask

   task automatic build_random(input int n_items, input logic [TYPE_WIDTH-1:0] drop);
      int                    start;
      int                    kind;
      int                    body;
      int                    form;
      logic [TYPE_WIDTH-1:0] seg_type;
      logic [WORD_WIDTH-1:0] len;
      stim_q.delete();
      start = stim_q.size();
      while (stim_q.size() - start < n_items) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            // plain character, never a segment mark
            push_item(16'($urandom_range(16'hFF7F)), $urandom_range(99) < 3);
         end else if (kind < 85) begin
            seg_type = $urandom_range(1) ? drop : 8'($urandom_range(255, 128));
            push_item({8'hFF, seg_type}, 1'b0);
            form = $urandom_range(9);
            body = 0;
            if (form < 6) begin
               len = 16'($urandom_range(24));
               push_item(len, 1'b0);
               body = int'(len >> 1);
            end else if (form < 9) begin
               len = 16'($urandom_range(24));
               push_item(LONG_LEN_MARK, 1'b0);
               push_item(len, 1'b0);
               push_item(16'h0000, 1'b0);
               body = int'(len >> 1);
            end else begin
               // big segment cut short by the end of the stream
               if ($urandom_range(1)) begin
                  push_item(16'($urandom_range(16'hFFFE, 16'h0040)), 1'b0);
               end else begin
                  push_item(LONG_LEN_MARK, 1'b0);
                  push_item(16'($urandom), 1'b0);
                  push_item(16'($urandom_range(16'hFFFF, 1)), 1'b0);
               end
               repeat ($urandom_range(6)) push_item(16'($urandom), 1'b0);
               push_item(16'($urandom), 1'b1);
            end
            for (int i = 0; i < body; i++) begin
               if ($urandom_range(3) == 0) push_item({8'hFF, 8'($urandom)}, 1'b0);
               else push_item(16'($urandom), 1'b0);
            end
         end else begin
            push_item(16'($urandom), $urandom_range(9) == 0);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed stream with the reset drop type 0xE0
      stim_q.delete();
      push_item(16'h0000, 1'b0);
      push_item(16'hFF7F, 1'b0);
      push_item(16'hFFE0, 1'b0);   // dropped segment, odd length rounds down
      push_item(16'h0005, 1'b0);
      push_item(16'hFFE0, 1'b0);   // mark inside a body is just body
      push_item(16'hFFFF, 1'b0);
      push_item(16'hFF80, 1'b0);   // kept segment with empty body
      push_item(16'h0001, 1'b0);
      push_item(16'h1234, 1'b0);
      push_item(16'hFFFF, 1'b0);   // kept segment with long length
      push_item(LONG_LEN_MARK, 1'b0);
      push_item(16'h0006, 1'b0);
      push_item(16'h0000, 1'b0);
      push_item(16'hABCD, 1'b0);
      push_item(16'hFFE0, 1'b0);
      push_item(16'h8000, 1'b0);
      push_item(16'hFFE0, 1'b0);   // dropped, long length below two
      push_item(LONG_LEN_MARK, 1'b0);
      push_item(16'h0001, 1'b0);
      push_item(16'h0000, 1'b0);
      push_item(16'hFFE0, 1'b0);   // dropped, zero length
      push_item(16'h0000, 1'b0);
      push_item(16'hFFE0, 1'b0);   // stream ends mid body
      push_item(16'h0100, 1'b0);
      push_item(16'h5555, 1'b1);
      push_item(16'hFFE0, 1'b1);
      push_item(16'h7FFF, 1'b1);
      drive_words(0);
      wait_drained();

      write_drop_type(8'd128);
      build_random(340, 8'd128);
      rsp_idle_pct = 50;
      drive_words(34);
      wait_drained();

      write_drop_type(8'd255);
      build_random(340, 8'd255);
      rsp_idle_pct = 34;
      drive_words(50);
      wait_drained();

      rsp_idle_pct = 0;
      write_drop_type(8'($urandom_range(255, 128)));
      build_random(340, sb.drop_type);
      // long receiver hold so the block fills and backs up its input
      @(negedge clock);
      stall_hold = HOLD_CYCLES;
      @(posedge clock);
      drive_words(0);
      wait_drained();
      repeat (4) @(posedge clock);

      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
